// ===== hdl/three_channel_compare_timer_top_assert.svh =====
// assertion macros for the compare timer
`ifndef THREE_CHANNEL_COMPARE_TIMER_TOP_ASSERT_SVH
`define THREE_CHANNEL_COMPARE_TIMER_TOP_ASSERT_SVH

`ifndef SYNTH
`define TCCT_ASSERT_IMPLY(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("timer assertion failed");
`define TCCT_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("timer assertion failed");
`else
`define TCCT_ASSERT_IMPLY(name, ante, cons)
`define TCCT_ASSERT_NEXT(name, ante, cons)
`endif

`endif

// ===== hdl/tcct_pkg.sv =====
package tcct_pkg;

	typedef logic [1:0] action_t;

	localparam action_t ACT_TICK  = 2'd0;
	localparam action_t ACT_READ  = 2'd1;
	localparam action_t ACT_WRITE = 2'd2;

	// per-channel register offsets
	localparam logic [5:0] OFF_CCR   = 6'h00;
	localparam logic [5:0] OFF_MODE  = 6'h04;
	localparam logic [5:0] OFF_COUNT = 6'h10;
	localparam logic [5:0] OFF_RA    = 6'h14;
	localparam logic [5:0] OFF_RB    = 6'h18;
	localparam logic [5:0] OFF_RC    = 6'h1c;
	localparam logic [5:0] OFF_SR    = 6'h20;
	localparam logic [5:0] OFF_IER   = 6'h24;
	localparam logic [5:0] OFF_IDR   = 6'h28;
	localparam logic [5:0] OFF_IMR   = 6'h2c;

	// block registers, always read as zero
	localparam logic [13:0] ADDR_BLOCK_CTRL = 14'h0c0;
	localparam logic [13:0] ADDR_BLOCK_MODE = 14'h0c4;
	localparam logic [13:0] ADDR_WINDOW_END = 14'h100;

	localparam int MODE_WAVE_BIT = 15;
	localparam int MODE_TRIG_BIT = 14;

	localparam logic [1:0] CCR_START = 2'b01;

	function automatic logic [10:0] clock_divisor(input logic [2:0] sel);
		logic [10:0] d;
		case (sel)
			3'd0: d = 11'd2;
			3'd1: d = 11'd8;
			3'd2: d = 11'd32;
			3'd3: d = 11'd128;
			3'd4: d = 11'd1024;
			default: d = 11'd16;
		endcase
		return d;
	endfunction

endpackage

// ===== hdl/three_channel_compare_timer_top.sv =====
// Three-channel compare-match timer behind a register bus. Each input word is a master
// clock tick, a register read or a register write, and each produces exactly one result
// word carrying the read data (zero for ticks, writes and unknown offsets) and the
// interrupt line of every channel (up to three) after the word took effect. One word is accepted per
// clock as long as results are taken every clock. A result is registered after its word
// is accepted: the word sits in the input register while the update logic works on it,
// and the channel state and result register load together when the result stage frees.
// While a finished result waits to be taken, one more word is accepted into the input
// register, and the input side then stalls until the waiting result is taken.
`include "three_channel_compare_timer_top_assert.svh"

module three_channel_compare_timer_top #(
	parameter int CHANNELS   = 3,
	parameter int COUNT_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tcct_pkg::action_t action,
	input  logic [13:0]       address,
	input  logic [31:0]       write_data,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [31:0]       read_data,
	output logic [2:0]        irq_lines
);
	import tcct_pkg::*;

	localparam int LINES = (CHANNELS < 3) ? CHANNELS : 3;
	localparam logic [COUNT_BITS-1:0] CNT_ONE = {{(COUNT_BITS-1){1'b0}}, 1'b1};

	// input stage
	logic              s1_valid_q;
	action_t           action_s1;
	logic [13:0]       address_s1;
	logic [31:0]       wdata_s1;

	// result stage
	logic              out_valid_q;
	logic [31:0]       rd_q;
	logic [2:0]        irq_q;

	// channel state
	logic [31:0]           mode_q   [CHANNELS];
	logic [COUNT_BITS-1:0] cnt_q    [CHANNELS];
	logic [COUNT_BITS-1:0] ra_q     [CHANNELS];
	logic [COUNT_BITS-1:0] rb_q     [CHANNELS];
	logic [COUNT_BITS-1:0] rc_q     [CHANNELS];
	logic [2:0]            stat_q   [CHANNELS];
	logic [31:0]           mask_q   [CHANNELS];
	logic                  line_q   [CHANNELS];
	logic                  run_q    [CHANNELS];
	logic [9:0]            pre_q    [CHANNELS];
	logic [COUNT_BITS-1:0] limit_q  [CHANNELS];
	logic [COUNT_BITS-1:0] period_q [CHANNELS];

	logic [31:0]           mode_d   [CHANNELS];
	logic [COUNT_BITS-1:0] cnt_d    [CHANNELS];
	logic [COUNT_BITS-1:0] ra_d     [CHANNELS];
	logic [COUNT_BITS-1:0] rb_d     [CHANNELS];
	logic [COUNT_BITS-1:0] rc_d     [CHANNELS];
	logic [2:0]            stat_d   [CHANNELS];
	logic [31:0]           mask_d   [CHANNELS];
	logic                  line_d   [CHANNELS];
	logic                  run_d    [CHANNELS];
	logic [9:0]            pre_d    [CHANNELS];
	logic [COUNT_BITS-1:0] limit_d  [CHANNELS];
	logic [COUNT_BITS-1:0] period_d [CHANNELS];

	logic        advance;
	logic        proc;
	logic        hit;
	logic [5:0]  off;
	logic [31:0] rd_d;
	logic [2:0]  irq_d;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !s1_valid_q || advance;
	assign proc     = s1_valid_q && advance;
	assign off      = address_s1[5:0];
	assign hit      = (address_s1 < ADDR_WINDOW_END)
		&& ({24'd0, address_s1[13:6]} < 32'(CHANNELS))
		&& (address_s1 != ADDR_BLOCK_CTRL) && (address_s1 != ADDR_BLOCK_MODE);

	always_comb begin
		logic [9:0]            pre_inc;
		logic [COUNT_BITS-1:0] cnt_inc;
		logic                  sel;
		logic                  do_tick;
		logic [COUNT_BITS-1:0] new_limit;
		rd_d = '0;
		pre_inc = '0;
		cnt_inc = '0;
		sel = 1'b0;
		do_tick = 1'b0;
		new_limit = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			mode_d[c]   = mode_q[c];
			cnt_d[c]    = cnt_q[c];
			ra_d[c]     = ra_q[c];
			rb_d[c]     = rb_q[c];
			rc_d[c]     = rc_q[c];
			stat_d[c]   = stat_q[c];
			mask_d[c]   = mask_q[c];
			line_d[c]   = line_q[c];
			run_d[c]    = run_q[c];
			pre_d[c]    = pre_q[c];
			limit_d[c]  = limit_q[c];
			period_d[c] = period_q[c];
			sel = hit && (address_s1[13:6] == 8'(c));
			do_tick = 1'b0;
			if (proc) begin
				case (action_s1)
					ACT_TICK: begin
						if (run_q[c]) begin
							pre_inc = pre_q[c] + 10'd1;
							if (pre_inc != 10'd0
								&& {1'b0, pre_inc} < clock_divisor(mode_q[c][2:0])) begin
								pre_d[c] = pre_inc;
							end else begin
								pre_d[c] = '0;
								if (period_q[c] <= CNT_ONE) begin
									period_d[c] = (limit_q[c] == '0) ? CNT_ONE : limit_q[c];
									do_tick = 1'b1;
								end else begin
									period_d[c] = period_q[c] - CNT_ONE;
								end
							end
						end
					end
					ACT_READ: begin
						if (sel) begin
							case (off)
								OFF_MODE:  rd_d = mode_q[c];
								OFF_COUNT: rd_d = 32'(cnt_q[c]);
								OFF_RA:    rd_d = 32'(ra_q[c]);
								OFF_RB:    rd_d = 32'(rb_q[c]);
								OFF_RC:    rd_d = 32'(rc_q[c]);
								OFF_SR: begin
									rd_d = {27'd0, stat_q[c], 2'b00};
									stat_d[c] = '0;
									line_d[c] = 1'b0;
								end
								OFF_IMR:   rd_d = mask_q[c];
								default:   rd_d = '0;
							endcase
						end
					end
					ACT_WRITE: begin
						if (sel) begin
							case (off)
								OFF_CCR: begin
									if (wdata_s1[1:0] == CCR_START) begin
										new_limit = limit_q[c];
										if (!mode_q[c][MODE_WAVE_BIT]) begin
											new_limit = (rc_q[c] == '0) ? CNT_ONE : rc_q[c];
										end
										limit_d[c]  = new_limit;
										cnt_d[c]    = '0;
										period_d[c] = new_limit;
										pre_d[c]    = '0;
										run_d[c]    = 1'b1;
									end else if (wdata_s1[1]) begin
										run_d[c]    = 1'b0;
										limit_d[c]  = CNT_ONE;
										period_d[c] = CNT_ONE;
									end
								end
								OFF_MODE: mode_d[c] = wdata_s1;
								OFF_RA:   ra_d[c] = wdata_s1[COUNT_BITS-1:0];
								OFF_RB:   rb_d[c] = wdata_s1[COUNT_BITS-1:0];
								OFF_RC:   rc_d[c] = wdata_s1[COUNT_BITS-1:0];
								OFF_IER:  mask_d[c] = mask_q[c] | wdata_s1;
								OFF_IDR:  mask_d[c] = mask_q[c] & ~wdata_s1;
								default: begin
								end
							endcase
						end
					end
					default: begin
					end
				endcase
			end
			if (do_tick) begin
				if (mode_q[c][MODE_WAVE_BIT]) begin
					cnt_inc = cnt_q[c] + CNT_ONE;
					cnt_d[c] = cnt_inc;
					if (cnt_inc == ra_q[c]) stat_d[c][0] = 1'b1;
					if (cnt_inc == rb_q[c]) stat_d[c][1] = 1'b1;
					if (cnt_inc == rc_q[c]) begin
						stat_d[c][2] = 1'b1;
						if (mode_q[c][MODE_TRIG_BIT]) cnt_d[c] = '0;
					end
				end else begin
					cnt_d[c] = mode_q[c][MODE_TRIG_BIT] ? '0 : rc_q[c];
					stat_d[c][2] = 1'b1;
				end
				if (|(stat_d[c] & mask_q[c][4:2])) line_d[c] = 1'b1;
			end
		end
		irq_d = '0;
		for (int i = 0; i < LINES; i++) begin
			irq_d[i] = line_d[i];
		end
	end

	// control and channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				mode_q[c]   <= '0;
				cnt_q[c]    <= '0;
				ra_q[c]     <= '0;
				rb_q[c]     <= '0;
				rc_q[c]     <= '0;
				stat_q[c]   <= '0;
				mask_q[c]   <= '0;
				line_q[c]   <= 1'b0;
				run_q[c]    <= 1'b0;
				pre_q[c]    <= '0;
				limit_q[c]  <= CNT_ONE;
				period_q[c] <= CNT_ONE;
			end
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
			end else if (advance) begin
				s1_valid_q <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= s1_valid_q;
			end
			for (int c = 0; c < CHANNELS; c++) begin
				mode_q[c]   <= mode_d[c];
				cnt_q[c]    <= cnt_d[c];
				ra_q[c]     <= ra_d[c];
				rb_q[c]     <= rb_d[c];
				rc_q[c]     <= rc_d[c];
				stat_q[c]   <= stat_d[c];
				mask_q[c]   <= mask_d[c];
				line_q[c]   <= line_d[c];
				run_q[c]    <= run_d[c];
				pre_q[c]    <= pre_d[c];
				limit_q[c]  <= limit_d[c];
				period_q[c] <= period_d[c];
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			action_s1  <= action;
			address_s1 <= address;
			wdata_s1   <= write_data;
		end
		if (proc) begin
			rd_q  <= rd_d;
			irq_q <= irq_d;
		end
	end

	assign out_valid = out_valid_q;
	assign read_data = rd_q;
	assign irq_lines = irq_q;

	// a held input word stays until the result stage frees up
	`TCCT_ASSERT_NEXT(a_s1_hold, s1_valid_q && !advance, s1_valid_q && $stable(address_s1))

	// an empty result stage never blocks the input side
	`TCCT_ASSERT_IMPLY(a_ready_when_empty, !out_valid_q, in_ready)

	// a raised line always has pending status behind it
	for (genvar g = 0; g < CHANNELS; g++) begin : g_line_chk
		`TCCT_ASSERT_IMPLY(a_line_has_status, line_q[g], stat_q[g] != 3'd0)
	end

endmodule
